// File: sv/srv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_pkg
// Shared widths, sideband types and rounding helper for the refraction core.
// ----------------------------------------------------------------------------
package srv_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int VEC_W     = 24;
  localparam int NRM_W     = 18;
  localparam int ETA_W     = 20;
  localparam int OUT_W     = 24;
  localparam int DT_W      = 21;
  localparam int LEN_W     = 31;
  localparam int SQ_IN_W   = 62;
  localparam int LEN_SHIFT = 14;

  // product clamp used when the normal is longer than unit length
  localparam logic [64:0]        PROD_SAT = 65'd1 << 61;
  localparam logic signed [63:0] OUT_MAX  = 64'sd8388607;
  localparam logic signed [63:0] OUT_MIN  = -64'sd8388608;

  // payload riding along the length square root
  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][VEC_W-1:0]  mag;
    logic [2:0][NRM_W-1:0]  nrm;
    logic [ETA_W-1:0]       eta;
  } dir_side_t;

  // payload riding along the normalizing divider
  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][NRM_W-1:0]  nrm;
    logic [ETA_W-1:0]       eta;
  } div_side_t;

  // x / 2^sh rounded half away from zero
  function automatic logic signed [63:0] rnd_half(input logic signed [63:0] x,
                                                  input int sh);
    logic signed [63:0] acc;
    acc = x + (64'sd1 <<< (sh - 1));
    if (x[63]) begin
      acc = acc - 64'sd1;
    end
    return acc >>> sh;
  endfunction

endpackage

// File: sv/srv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module srv_sqrt #(
  parameter int IN_W   = 62,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int STEPS = IN_W / 2;
  localparam int RW    = STEPS + 3;

  logic [RW-1:0]     rem_q  [STEPS];
  logic [STEPS-1:0]  root_q [STEPS];
  logic [IN_W-1:0]   rad_q  [STEPS];
  logic              vld_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW-1:0]     rem_in;
    logic [STEPS-1:0]  root_in;
    logic [IN_W-1:0]   rad_in;
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     cur;
    logic [RW-1:0]     trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign cur   = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial = RW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
      if (cur >= trial) begin
        rem_q[k]  <= cur - trial;
        root_q[k] <= {root_in[STEPS-2:0], 1'b1};
      end else begin
        rem_q[k]  <= cur;
        root_q[k] <= {root_in[STEPS-2:0], 1'b0};
      end
      rad_q[k]  <= {rad_in[IN_W-3:0], 2'b00};
      side_q[k] <= side_in;
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign root      = root_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule

// File: sv/srv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_div
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module srv_div #(
  parameter int NW     = 48,
  parameter int QW     = 18,
  parameter int DW     = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NW-1:0]     num [3],
  input  logic [DW-1:0]     divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     quot [3],
  output logic [SIDE_W-1:0] out_side
);

  localparam int LANES = 3;

  logic [DW-1:0]     rem_q  [QW][LANES];
  logic [QW-1:0]     lq_q   [QW][LANES];
  logic [DW-1:0]     dvs_q  [QW];
  logic              vld_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0]     dvs_in;
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign dvs_in  = divisor;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign dvs_in  = dvs_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
      dvs_q[k]  <= dvs_in;
      side_q[k] <= side_in;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lq_in;
      logic [DW:0]   cur;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_in = DW'(num[l][NW-1:QW]);
        assign lq_in  = num[l][QW-1:0];
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign lq_in  = lq_q[k-1][l];
      end

      // low numerator bits shift out as quotient bits shift in
      assign cur = {rem_in, lq_in[QW-1]};
      assign ge  = cur >= {1'b0, dvs_in};

      always_ff @(posedge clk) begin
        rem_q[k][l] <= ge ? DW'(cur - {1'b0, dvs_in}) : DW'(cur);
        lq_q[k][l]  <= {lq_in[QW-2:0], ge};
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_side  = side_q[QW-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot[l] = lq_q[QW-1][l];
  end

endmodule

// File: sv/snell_refraction_vector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snell_refraction_vector_core
// Snell refraction of a ray direction in signed fixed point: normalize the
// incident vector, test for total internal reflection, form the refracted ray.
// ----------------------------------------------------------------------------
// A new item may be started in every clock cycle; busy is always low. Each
// item comes out as a one-cycle done strobe with refract_ok and the refracted
// vector. Results cannot be held off, so the receiver must take every done
// cycle. The depth is set by two 31-step square root pipelines (vector length
// and the discriminant root) and the FRAC_BITS + 2 step normalizing divider.
// A zero incident vector is treated as a zero direction; a non-positive
// discriminant returns refract_ok low and a zero vector.
module snell_refraction_vector_core import srv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VEC_W-1:0] incident_x,
  input  logic signed [VEC_W-1:0] incident_y,
  input  logic signed [VEC_W-1:0] incident_z,
  input  logic signed [NRM_W-1:0] normal_x,
  input  logic signed [NRM_W-1:0] normal_y,
  input  logic signed [NRM_W-1:0] normal_z,
  input  logic [ETA_W-1:0]        index_ratio,
  output logic                    done,
  output logic                    refract_ok,
  output logic signed [OUT_W-1:0] refracted_x,
  output logic signed [OUT_W-1:0] refracted_y,
  output logic signed [OUT_W-1:0] refracted_z
);

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 2;
  localparam int QW   = F + 2;
  localparam int NW   = F + 32;
  localparam int AW   = ((F > 18) ? F : 36 - F) + 3;
  localparam int E2W  = 41 - F;
  localparam int TMW  = ((F > 19) ? F : 38 - F) + 1;
  localparam int PW   = UW + NRM_W;
  localparam int ACCW = PW + 2;
  localparam int PEW  = AW + ETA_W + 1;
  localparam int PSW  = NRM_W + LEN_W + 1;
  localparam int REW  = 22 + AW - F;
  localparam int RSW  = 51 - F;

  localparam logic signed [63:0] ONE     = 64'sd1 <<< F;
  localparam logic [QW-1:0]      ONE_Q   = QW'(1) << F;
  localparam logic signed [63:0] NEG_SAT = -(64'sd1 <<< 61);

  typedef struct packed {
    logic                  ok;
    logic [2:0][AW-1:0]    a;
    logic [2:0][NRM_W-1:0] nrm;
    logic [ETA_W-1:0]      eta;
  } dsc_side_t;

  assign busy = 1'b0;

  // input capture
  logic                    s0_v;
  logic signed [VEC_W-1:0] s0_vec [3];
  logic signed [NRM_W-1:0] s0_nrm [3];
  logic [ETA_W-1:0]        s0_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= start;
    end
    s0_vec[0] <= incident_x;
    s0_vec[1] <= incident_y;
    s0_vec[2] <= incident_z;
    s0_nrm[0] <= normal_x;
    s0_nrm[1] <= normal_y;
    s0_nrm[2] <= normal_z;
    s0_eta    <= index_ratio;
  end

  // squares and magnitudes
  logic             p1_v;
  logic [46:0]      p1_sq [3];
  dir_side_t        p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= s0_v;
    end
    for (int i = 0; i < 3; i++) begin
      p1_sq[i]          <= 47'(s0_vec[i] * s0_vec[i]);
      p1_side.neg[i]    <= s0_vec[i][VEC_W-1];
      p1_side.mag[i]    <= s0_vec[i][VEC_W-1] ? VEC_W'(-s0_vec[i]) : VEC_W'(s0_vec[i]);
      p1_side.nrm[i]    <= s0_nrm[i];
    end
    p1_side.eta <= s0_eta;
  end

  // squared length
  logic       p2_v;
  logic [47:0] p2_ssq;
  dir_side_t  p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
    p2_ssq  <= 48'(p1_sq[0]) + 48'(p1_sq[1]) + 48'(p1_sq[2]);
    p2_side <= p1_side;
  end

  // vector length
  logic             len_v;
  logic [LEN_W-1:0] len_r;
  dir_side_t        len_side;

  srv_sqrt #(
    .IN_W   (SQ_IN_W),
    .SIDE_W ($bits(dir_side_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_v),
    .radicand  ({p2_ssq, {LEN_SHIFT{1'b0}}}),
    .in_side   (p2_side),
    .out_valid (len_v),
    .root      (len_r),
    .out_side  (len_side)
  );

  // rounded numerators for normalization
  logic             d0_v;
  logic [NW-1:0]    d0_num [3];
  logic [LEN_W-1:0] d0_len;
  div_side_t        d0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
    end else begin
      d0_v <= len_v;
    end
    for (int i = 0; i < 3; i++) begin
      d0_num[i] <= (NW'(len_side.mag[i]) << (F + 7)) + NW'(len_r >> 1);
    end
    d0_len       <= len_r;
    d0_side.zero <= (len_r == '0);
    d0_side.neg  <= len_side.neg;
    d0_side.nrm  <= len_side.nrm;
    d0_side.eta  <= len_side.eta;
  end

  logic          dv_v;
  logic [QW-1:0] dv_q [3];
  div_side_t     dv_side;

  srv_div #(
    .NW     (NW),
    .QW     (QW),
    .DW     (LEN_W),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d0_v),
    .num       (d0_num),
    .divisor   (d0_len),
    .in_side   (d0_side),
    .out_valid (dv_v),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  // unit vector: clamp, sign, zero vector
  logic signed [UW-1:0] u_next [3];
  logic [QW-1:0]        qc     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[i] > ONE_Q) ? ONE_Q : dv_q[i];
      if (dv_side.zero) begin
        u_next[i] = '0;
      end else if (dv_side.neg[i]) begin
        u_next[i] = -$signed(qc[i]);
      end else begin
        u_next[i] = $signed(qc[i]);
      end
    end
  end

  logic                 u_v;
  logic signed [UW-1:0] u_u   [3];
  logic [NRM_W-1:0]     u_nrm [3];
  logic [ETA_W-1:0]     u_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_v <= 1'b0;
    end else begin
      u_v <= dv_v;
    end
    for (int i = 0; i < 3; i++) begin
      u_u[i]   <= u_next[i];
      u_nrm[i] <= dv_side.nrm[i];
    end
    u_eta <= dv_side.eta;
  end

  // M1: u.n partial products, eta squared
  logic                    m1_v;
  logic signed [PW-1:0]    m1_pu  [3];
  logic signed [UW-1:0]    m1_u   [3];
  logic signed [NRM_W-1:0] m1_nrm [3];
  logic [ETA_W-1:0]        m1_eta;
  logic [2*ETA_W-1:0]      m1_e2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= u_v;
    end
    for (int i = 0; i < 3; i++) begin
      m1_pu[i]  <= u_u[i] * $signed(u_nrm[i]);
      m1_u[i]   <= u_u[i];
      m1_nrm[i] <= $signed(u_nrm[i]);
    end
    m1_eta <= u_eta;
    m1_e2r <= u_eta * u_eta;
  end

  // M2: dot product sum
  logic                    m2_v;
  logic signed [ACCW-1:0]  m2_acc;
  logic signed [UW-1:0]    m2_u   [3];
  logic signed [NRM_W-1:0] m2_nrm [3];
  logic [ETA_W-1:0]        m2_eta;
  logic [2*ETA_W-1:0]      m2_e2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else begin
      m2_v <= m1_v;
    end
    m2_acc <= ACCW'(m1_pu[0]) + ACCW'(m1_pu[1]) + ACCW'(m1_pu[2]);
    m2_u   <= m1_u;
    m2_nrm <= m1_nrm;
    m2_eta <= m1_eta;
    m2_e2r <= m1_e2r;
  end

  // M3: round dt and eta^2
  logic                    m3_v;
  logic signed [DT_W-1:0]  m3_dt;
  logic [E2W-1:0]          m3_e2;
  logic signed [UW-1:0]    m3_u   [3];
  logic signed [NRM_W-1:0] m3_nrm [3];
  logic [ETA_W-1:0]        m3_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else begin
      m3_v <= m2_v;
    end
    m3_dt  <= DT_W'(rnd_half(64'(m2_acc), F));
    m3_e2  <= E2W'(rnd_half($signed(64'(m2_e2r)), F));
    m3_u   <= m2_u;
    m3_nrm <= m2_nrm;
    m3_eta <= m2_eta;
  end

  // M4: dt^2 and n*dt
  logic                          m4_v;
  logic signed [2*DT_W-1:0]      m4_dd;
  logic signed [NRM_W+DT_W-1:0]  m4_nd  [3];
  logic [E2W-1:0]                m4_e2;
  logic signed [UW-1:0]          m4_u   [3];
  logic signed [NRM_W-1:0]       m4_nrm [3];
  logic [ETA_W-1:0]              m4_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else begin
      m4_v <= m3_v;
    end
    m4_dd <= m3_dt * m3_dt;
    for (int i = 0; i < 3; i++) begin
      m4_nd[i] <= m3_nrm[i] * m3_dt;
    end
    m4_e2  <= m3_e2;
    m4_u   <= m3_u;
    m4_nrm <= m3_nrm;
    m4_eta <= m3_eta;
  end

  // M5: t = 1 - dt^2, tangential part a = u - n dt
  logic                    m5_v;
  logic signed [TMW:0]     m5_t;
  logic signed [AW-1:0]    m5_a   [3];
  logic [E2W-1:0]          m5_e2;
  logic signed [NRM_W-1:0] m5_nrm [3];
  logic [ETA_W-1:0]        m5_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_v <= 1'b0;
    end else begin
      m5_v <= m4_v;
    end
    m5_t <= (TMW + 1)'(ONE - rnd_half(64'(m4_dd), F));
    for (int i = 0; i < 3; i++) begin
      m5_a[i] <= AW'(64'(m4_u[i]) - rnd_half(64'(m4_nd[i]), F));
    end
    m5_e2  <= m4_e2;
    m5_nrm <= m4_nrm;
    m5_eta <= m4_eta;
  end

  // M6: magnitude product e2 * |t|
  logic [TMW-1:0] t_mag;

  assign t_mag = m5_t[TMW] ? TMW'(-m5_t) : TMW'(m5_t);

  logic                    m6_v;
  logic                    m6_neg;
  logic [E2W+TMW-1:0]      m6_prod;
  logic signed [AW-1:0]    m6_a   [3];
  logic signed [NRM_W-1:0] m6_nrm [3];
  logic [ETA_W-1:0]        m6_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m6_v <= 1'b0;
    end else begin
      m6_v <= m5_v;
    end
    m6_neg  <= m5_t[TMW];
    m6_prod <= m5_e2 * t_mag;
    m6_a    <= m5_a;
    m6_nrm  <= m5_nrm;
    m6_eta  <= m5_eta;
  end

  // M7: signed product, clamped when t is negative and large
  logic                    m7_v;
  logic signed [63:0]      m7_p;
  logic signed [AW-1:0]    m7_a   [3];
  logic signed [NRM_W-1:0] m7_nrm [3];
  logic [ETA_W-1:0]        m7_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m7_v <= 1'b0;
    end else begin
      m7_v <= m6_v;
    end
    if (!m6_neg) begin
      m7_p <= $signed(64'(m6_prod));
    end else if (65'(m6_prod) > PROD_SAT) begin
      m7_p <= NEG_SAT;
    end else begin
      m7_p <= -$signed(64'(m6_prod));
    end
    m7_a   <= m6_a;
    m7_nrm <= m6_nrm;
    m7_eta <= m6_eta;
  end

  // M8: discriminant
  logic                    m8_v;
  logic signed [63:0]      m8_disc;
  logic signed [AW-1:0]    m8_a   [3];
  logic signed [NRM_W-1:0] m8_nrm [3];
  logic [ETA_W-1:0]        m8_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m8_v <= 1'b0;
    end else begin
      m8_v <= m7_v;
    end
    m8_disc <= ONE - rnd_half(m7_p, F);
    m8_a    <= m7_a;
    m8_nrm  <= m7_nrm;
    m8_eta  <= m7_eta;
  end

  logic [63:0] disc_sh;
  dsc_side_t   m8_side;

  assign disc_sh = m8_disc << F;

  always_comb begin
    m8_side.ok  = (m8_disc > 64'sd0);
    for (int i = 0; i < 3; i++) begin
      m8_side.a[i]   = m8_a[i];
      m8_side.nrm[i] = m8_nrm[i];
    end
    m8_side.eta = m8_eta;
  end

  // sqrt of the discriminant
  logic             sq_v;
  logic [LEN_W-1:0] sq_root;
  dsc_side_t        sq_side;

  srv_sqrt #(
    .IN_W   (SQ_IN_W),
    .SIDE_W ($bits(dsc_side_t))
  ) u_disc_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m8_v),
    .radicand  (disc_sh[SQ_IN_W-1:0]),
    .in_side   (m8_side),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // X1: eta * a and n * s
  logic                  x1_v;
  logic                  x1_ok;
  logic signed [PEW-1:0] x1_pe [3];
  logic signed [PSW-1:0] x1_ps [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
    end else begin
      x1_v <= sq_v;
    end
    x1_ok <= sq_side.ok;
    for (int i = 0; i < 3; i++) begin
      x1_pe[i] <= $signed({1'b0, sq_side.eta}) * $signed(sq_side.a[i]);
      x1_ps[i] <= $signed(sq_side.nrm[i]) * $signed({1'b0, sq_root});
    end
  end

  // X2: round both terms
  logic                  x2_v;
  logic                  x2_ok;
  logic signed [REW-1:0] x2_re [3];
  logic signed [RSW-1:0] x2_rs [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_v <= 1'b0;
    end else begin
      x2_v <= x1_v;
    end
    x2_ok <= x1_ok;
    for (int i = 0; i < 3; i++) begin
      x2_re[i] <= REW'(rnd_half(64'(x1_pe[i]), F));
      x2_rs[i] <= RSW'(rnd_half(64'(x1_ps[i]), F));
    end
  end

  // X3: difference, saturation, zero on total internal reflection
  logic signed [63:0]      r_full [3];
  logic signed [OUT_W-1:0] r_sat  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_full[i] = 64'(x2_re[i]) - 64'(x2_rs[i]);
      if (!x2_ok) begin
        r_sat[i] = '0;
      end else if (r_full[i] > OUT_MAX) begin
        r_sat[i] = OUT_W'(OUT_MAX);
      end else if (r_full[i] < OUT_MIN) begin
        r_sat[i] = OUT_W'(OUT_MIN);
      end else begin
        r_sat[i] = OUT_W'(r_full[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x2_v;
    end
    refract_ok  <= x2_ok;
    refracted_x <= r_sat[0];
    refracted_y <= r_sat[1];
    refracted_z <= r_sat[2];
  end

endmodule

// File: sim/tb_snell_refraction_vector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_snell_refraction_vector_core
// Self-checking bench for the refraction core. Directed rays cover the field
// extremes, a zero incident vector, total internal reflection, a zero
// discriminant and normals longer than unit length. Random rays follow, most
// of them with unit normals and moderate index ratios. A bit-exact fixed-point
// predictor computes each expected result. A scoreboard compares every done
// strobe, in order, with the oldest expected item.
// ----------------------------------------------------------------------------
module tb_snell_refraction_vector_core;
  import srv_pkg::*;

  localparam int FB         = FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 1500;
  localparam int LATENCY    = 79 + FB;
  localparam int IDLE_LIMIT = 20 * LATENCY;

  typedef struct {
    logic signed [VEC_W-1:0] inc [3];
    logic signed [NRM_W-1:0] nrm [3];
    logic [ETA_W-1:0]        eta;
  } ray_t;

  typedef struct {
    logic                    ok;
    logic signed [OUT_W-1:0] dir [3];
  } refr_t;

  // rounded shift, half away from zero
  function automatic longint shift_round(longint x, int sh);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // expected refracted direction for one ray
  function automatic refr_t refract_predict(ray_t r);
    refr_t           o;
    longint          v [3], n [3], u [3];
    longint          one, eta, acc, dt, t, e2, p, disc, s, a, d, mg;
    longint unsigned ssq, len, mag, q;
    one = longint'(1) << FB;
    eta = longint'(r.eta);
    ssq = 0;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(r.inc[i]);
      n[i] = longint'(r.nrm[i]);
      ssq  = ssq + longint'(v[i] * v[i]);
    end
    len = int_sqrt(ssq << LEN_SHIFT);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        mag  = (v[i] < 0) ? -v[i] : v[i];
        q    = ((mag << (FB + 7)) + len / 2) / len;
        if (q > one) q = one;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      acc = acc + u[i] * n[i];
    end
    dt = shift_round(acc, FB);
    t  = one - shift_round(dt * dt, FB);
    e2 = shift_round(eta * eta, FB);
    if (t >= 0) begin
      p = e2 * t;
    end else begin
      mg = -t;
      if (e2 != 0 && mg > (longint'(1) << 61) / e2) p = -(longint'(1) << 61);
      else p = -(e2 * mg);
    end
    disc = one - shift_round(p, FB);
    o.ok = 1'b0;
    for (int i = 0; i < 3; i++) o.dir[i] = '0;
    if (disc > 0) begin
      s    = int_sqrt(longint'(disc) << FB);
      o.ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        a = u[i] - shift_round(n[i] * dt, FB);
        d = shift_round(eta * a, FB) - shift_round(n[i] * s, FB);
        if (d > OUT_MAX) d = OUT_MAX;
        if (d < OUT_MIN) d = OUT_MIN;
        o.dir[i] = d[OUT_W-1:0];
      end
    end
    return o;
  endfunction

  // in-order scoreboard of refraction results
  class refr_scoreboard;
    refr_t pending [$];
    int    errors, seen, tir_seen;

    function void note_ray(ray_t r);
      pending.push_back(refract_predict(r));
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %0s at result %0d: got %0d expected %0d", what, seen, got, want);
    endtask

    task check_result(refr_t got);
      refr_t want;
      if (pending.size() == 0) begin
        report("unexpected result", longint'(got.ok), -1);
      end else begin
        want = pending.pop_front();
        if (got.ok !== want.ok) report("refract_ok", longint'(got.ok), longint'(want.ok));
        for (int i = 0; i < 3; i++)
          if (got.dir[i] !== want.dir[i])
            report("refracted", longint'(got.dir[i]), longint'(want.dir[i]));
        if (!want.ok) tir_seen++;
      end
      seen++;
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy, done, refract_ok;
  logic signed [VEC_W-1:0] incident_x = '0, incident_y = '0, incident_z = '0;
  logic signed [NRM_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [ETA_W-1:0]        index_ratio = '0;
  logic signed [OUT_W-1:0] refracted_x, refracted_y, refracted_z;

  refr_scoreboard sb = new();
  int             idle_cycles = 0;
  int             rays_sent = 0;

  always #10 clk = ~clk;

  snell_refraction_vector_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .incident_x(incident_x), .incident_y(incident_y), .incident_z(incident_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .index_ratio(index_ratio), .done(done), .refract_ok(refract_ok),
    .refracted_x(refracted_x), .refracted_y(refracted_y), .refracted_z(refracted_z)
  );

  // monitor: accepted items, results and the watchdog
  always @(posedge clk) begin
    ray_t  r;
    refr_t g;
    if (!rst) begin
      if (start && !busy) begin
        r.inc[0] = incident_x; r.inc[1] = incident_y; r.inc[2] = incident_z;
        r.nrm[0] = normal_x;   r.nrm[1] = normal_y;   r.nrm[2] = normal_z;
        r.eta    = index_ratio;
        sb.note_ray(r);
      end
      if (done) begin
        g.ok = refract_ok;
        g.dir[0] = refracted_x; g.dir[1] = refracted_y; g.dir[2] = refracted_z;
        sb.check_result(g);
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // drive one ray and hold it until the core takes it
  task send_ray(ray_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    incident_x  <= r.inc[0]; incident_y <= r.inc[1]; incident_z <= r.inc[2];
    normal_x    <= r.nrm[0]; normal_y   <= r.nrm[1]; normal_z   <= r.nrm[2];
    index_ratio <= r.eta;
    @(posedge clk);
    while (busy) @(posedge clk);
    rays_sent++;
  endtask

  function automatic ray_t make_ray(longint ix, longint iy, longint iz,
                                    longint nx, longint ny, longint nz, longint e);
    ray_t r;
    r.inc[0] = VEC_W'(ix); r.inc[1] = VEC_W'(iy); r.inc[2] = VEC_W'(iz);
    r.nrm[0] = NRM_W'(nx); r.nrm[1] = NRM_W'(ny); r.nrm[2] = NRM_W'(nz);
    r.eta    = ETA_W'(e);
    return r;
  endfunction

  // random ray: mostly unit normals and moderate ratios, some raw noise
  function automatic ray_t random_ray();
    ray_t r;
    real  c [3], m;
    int   kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0: r.inc[i] = VEC_W'($urandom);
        1: r.inc[i] = VEC_W'(int'($urandom_range(0, 131072)) - 65536);
        2: r.inc[i] = VEC_W'(int'($urandom_range(0, 512)) - 256);
        default: r.inc[i] = VEC_W'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
    end
    if (kind < 8) begin
      m = 0.0;
      for (int i = 0; i < 3; i++) begin
        c[i] = real'(int'($urandom_range(0, 200000)) - 100000);
        m    = m + c[i] * c[i];
      end
      if (m == 0.0) begin c[2] = 1.0; m = 1.0; end
      m = $sqrt(m);
      for (int i = 0; i < 3; i++) r.nrm[i] = NRM_W'($rtoi(c[i] / m * 65536.0));
      r.eta = (kind < 6) ? ETA_W'($urandom_range(32768, 131072))
                         : ETA_W'($urandom_range(0, 262143));
    end else begin
      for (int i = 0; i < 3; i++) r.nrm[i] = NRM_W'($urandom);
      r.eta = ETA_W'($urandom);
    end
    return r;
  endfunction

  initial begin
    ray_t directed [$];
    int   gap;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero vector, grazing, zero discriminant, long normals
    directed.push_back(make_ray(0, 0, 0, 0, 0, 65536, 65536));
    directed.push_back(make_ray(0, 0, 0, 0, 0, 65536, 0));
    directed.push_back(make_ray(0, 0, 0, 0, 65536, 0, 1048575));
    directed.push_back(make_ray(8388607, 8388607, 8388607, 65536, 0, 0, 65536));
    directed.push_back(make_ray(-8388608, -8388608, -8388608, -65536, 0, 0, 49152));
    directed.push_back(make_ray(8388607, -8388608, 0, 0, -65536, 0, 98304));
    directed.push_back(make_ray(0, 0, -65536, 0, 0, 65536, 43690));
    directed.push_back(make_ray(0, 0, -65536, 0, 0, 65536, 98304));
    directed.push_back(make_ray(65536, 0, -1, 0, 0, 65536, 98304));
    directed.push_back(make_ray(65536, 0, 0, 0, 0, 65536, 65536));
    directed.push_back(make_ray(65536, 0, 0, 0, 0, 65536, 32768));
    directed.push_back(make_ray(46341, 0, -46341, 0, 0, 65536, 98304));
    directed.push_back(make_ray(1, 0, 0, 0, 0, -65536, 65536));
    directed.push_back(make_ray(-1, -1, -1, 37837, 37837, 37837, 65536));
    directed.push_back(make_ray(0, 0, 8388607, 0, 0, 131071, 1048575));
    directed.push_back(make_ray(0, 0, -8388608, 0, 0, -131072, 1048575));
    directed.push_back(make_ray(8388607, 8388607, 8388607, 131071, 131071, 131071, 1));
    directed.push_back(make_ray(-8388608, 1, -1, -131072, -131072, -131072, 0));
    directed.push_back(make_ray(0, -65536, 0, 0, 65536, 0, 1048575));
    directed.push_back(make_ray(12345, -54321, 777, 0, 0, 0, 65536));
    foreach (directed[k]) send_ray(directed[k], k % 3);

    // let the pipeline drain fully before the random part
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      gap = ((k / 100) % 3 == 0) ? 0 : $urandom_range(0, 8);
      if (k == NUM_RANDOM / 2) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_ray(random_ray(), gap);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d rays, %0d results checked, %0d of them total internal reflection",
             rays_sent, sb.seen, sb.tir_seen);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
